[hdl/xeu_pkg.sv]
// Package for the XML entity unescaper: character codes, numeric limits,
// output source selects and the command/status structs between controller and datapath.
// No dependencies.
`timescale 1ns / 1ps

package xeu_pkg;

	localparam int ENTITY_WINDOW_DEF = 10;

	// Width of the running numeric reference value; large enough for the code point limit.
	localparam int NUM_W = 21;
	localparam logic [NUM_W-1:0] NUM_LIMIT = 21'h10FFFF;
	localparam logic [NUM_W-1:0] ASCII_LIMIT = 21'h000080;

	localparam logic [7:0] CH_AMP   = 8'h26;
	localparam logic [7:0] CH_SEMI  = 8'h3B;
	localparam logic [7:0] CH_HASH  = 8'h23;
	localparam logic [7:0] CH_LT    = 8'h3C;
	localparam logic [7:0] CH_GT    = 8'h3E;
	localparam logic [7:0] CH_QUOT  = 8'h22;
	localparam logic [7:0] CH_APOS  = 8'h27;
	localparam logic [7:0] CH_LX    = 8'h78;
	localparam logic [7:0] CH_UX    = 8'h58;
	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_9     = 8'h39;
	localparam logic [7:0] CH_LA    = 8'h61;
	localparam logic [7:0] CH_LF    = 8'h66;
	localparam logic [7:0] CH_UA    = 8'h41;
	localparam logic [7:0] CH_UF    = 8'h46;
	localparam logic [7:0] CH_LG    = 8'h67;
	localparam logic [7:0] CH_LL    = 8'h6C;
	localparam logic [7:0] CH_LM    = 8'h6D;
	localparam logic [7:0] CH_LO    = 8'h6F;
	localparam logic [7:0] CH_LP    = 8'h70;
	localparam logic [7:0] CH_LQ    = 8'h71;
	localparam logic [7:0] CH_LS    = 8'h73;
	localparam logic [7:0] CH_LT_T  = 8'h74;
	localparam logic [7:0] CH_LU    = 8'h75;

	// Source of the byte loaded into the output register.
	typedef logic [2:0] emit_sel_t;
	localparam emit_sel_t EMIT_IN   = 3'd0;
	localparam emit_sel_t EMIT_AMP  = 3'd1;
	localparam emit_sel_t EMIT_SEMI = 3'd2;
	localparam emit_sel_t EMIT_HEAD = 3'd3;
	localparam emit_sel_t EMIT_DEC  = 3'd4;

	typedef struct packed {
		logic      load_in;
		logic      append;
		logic      pop;
		logic      clr_count;
		logic      set_open;
		logic      clr_open;
		logic      dec_start;
		logic      dec_step;
		logic      emit;
		emit_sel_t emit_sel;
		logic      emit_last;
	} dp_cmd_t;

	typedef struct packed {
		logic c_amp;
		logic c_semi;
		logic last;
		logic open;
		logic count_zero;
		logic count_one;
		logic count_full;
		logic head_amp;
		logic k_end;
		logic decode_ok;
		logic slot_free;
	} dp_status_t;

	// Returns {valid, value} for one digit of a numeric reference.
	function automatic logic [4:0] digit_value(input logic [7:0] ch, input logic hex);
		logic [4:0] r;
		r = 5'd0;
		if (ch >= CH_0 && ch <= CH_9) begin
			r = {1'b1, 4'(ch - CH_0)};
		end else if (hex && ch >= CH_LA && ch <= CH_LF) begin
			r = {1'b1, 4'(ch - CH_LA + 8'd10)};
		end else if (hex && ch >= CH_UA && ch <= CH_UF) begin
			r = {1'b1, 4'(ch - CH_UA + 8'd10)};
		end
		return r;
	endfunction

endpackage

[hdl/xeu_dp.sv]
// Datapath of the XML entity unescaper: input register, held entity shift buffer,
// numeric reference scanner, name matcher and output register.
// Depends on xeu_pkg.
`timescale 1ns / 1ps

module xeu_dp #(
	parameter int ENTITY_WINDOW = xeu_pkg::ENTITY_WINDOW_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [7:0]          in_byte,
	input  logic                in_last,
	output logic [7:0]          out_byte,
	output logic                out_last,
	output logic                out_valid,
	input  logic                out_ready,
	input  xeu_pkg::dp_cmd_t    cmd,
	output xeu_pkg::dp_status_t st
);

	localparam int CNT_W = $clog2(ENTITY_WINDOW + 1);
	localparam int IDX_W = $clog2(ENTITY_WINDOW);
	localparam int CAP   = ENTITY_WINDOW - 1;
	localparam int PRD_W = xeu_pkg::NUM_W + 4;

	logic [7:0]               c_q;
	logic                     last_q;
	logic [7:0]               held_q [ENTITY_WINDOW];
	logic [CNT_W-1:0]         count_q;
	logic                     open_q;
	logic [IDX_W-1:0]         k_q;
	logic [xeu_pkg::NUM_W-1:0] val_q;
	logic                     hex_q;
	logic                     bad_q;
	logic [7:0]               out_byte_q;
	logic                     out_last_q;
	logic                     out_valid_q;

	logic [7:0]       scan_ch;
	logic [4:0]       dig;
	logic [PRD_W-1:0] prod;
	logic [PRD_W-1:0] val_next;
	logic             named_hit;
	logic [7:0]       named_char;
	logic [7:0]       dec_byte;
	logic [7:0]       emit_byte;
	logic             num_ok;

	// Numeric scanner: one held character per step.
	assign scan_ch  = held_q[k_q];
	assign dig      = xeu_pkg::digit_value(scan_ch, hex_q);
	assign prod     = hex_q ? {val_q, 4'b0000}
	                        : PRD_W'({val_q, 3'b000}) + PRD_W'({val_q, 1'b0});
	assign val_next = prod + PRD_W'(dig[3:0]);

	// The five named entities, matched on fixed places of the buffer.
	always_comb begin
		named_hit  = 1'b0;
		named_char = xeu_pkg::CH_AMP;
		if (count_q == CNT_W'(3) && held_q[0] == xeu_pkg::CH_LA
				&& held_q[1] == xeu_pkg::CH_LM && held_q[2] == xeu_pkg::CH_LP) begin
			named_hit  = 1'b1;
			named_char = xeu_pkg::CH_AMP;
		end else if (count_q == CNT_W'(2) && held_q[0] == xeu_pkg::CH_LL
				&& held_q[1] == xeu_pkg::CH_LT_T) begin
			named_hit  = 1'b1;
			named_char = xeu_pkg::CH_LT;
		end else if (count_q == CNT_W'(2) && held_q[0] == xeu_pkg::CH_LG
				&& held_q[1] == xeu_pkg::CH_LT_T) begin
			named_hit  = 1'b1;
			named_char = xeu_pkg::CH_GT;
		end else if (count_q == CNT_W'(4) && held_q[0] == xeu_pkg::CH_LQ
				&& held_q[1] == xeu_pkg::CH_LU && held_q[2] == xeu_pkg::CH_LO
				&& held_q[3] == xeu_pkg::CH_LT_T) begin
			named_hit  = 1'b1;
			named_char = xeu_pkg::CH_QUOT;
		end else if (count_q == CNT_W'(4) && held_q[0] == xeu_pkg::CH_LA
				&& held_q[1] == xeu_pkg::CH_LP && held_q[2] == xeu_pkg::CH_LO
				&& held_q[3] == xeu_pkg::CH_LS) begin
			named_hit  = 1'b1;
			named_char = xeu_pkg::CH_APOS;
		end
	end

	assign num_ok   = !bad_q && count_q != '0 && val_q != '0 && val_q < xeu_pkg::ASCII_LIMIT;
	assign dec_byte = named_hit ? named_char : val_q[7:0];

	always_comb begin
		case (cmd.emit_sel)
			xeu_pkg::EMIT_IN:   emit_byte = c_q;
			xeu_pkg::EMIT_AMP:  emit_byte = xeu_pkg::CH_AMP;
			xeu_pkg::EMIT_SEMI: emit_byte = xeu_pkg::CH_SEMI;
			xeu_pkg::EMIT_HEAD: emit_byte = held_q[0];
			xeu_pkg::EMIT_DEC:  emit_byte = dec_byte;
			default:            emit_byte = c_q;
		endcase
	end

	// Input register.
	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			c_q    <= in_byte;
			last_q <= in_last;
		end
	end

	// Held buffer: written at the fill position, shifted towards the head on a pop.
	for (genvar i = 0; i < ENTITY_WINDOW; i++) begin : g_held
		always_ff @(posedge clk) begin
			if (cmd.append && count_q[IDX_W-1:0] == IDX_W'(i)) begin
				held_q[i] <= c_q;
			end else if (cmd.pop) begin
				if (i < ENTITY_WINDOW - 1) begin
					held_q[i] <= held_q[(i + 1) % ENTITY_WINDOW];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			open_q  <= 1'b0;
		end else begin
			if (cmd.clr_count) begin
				count_q <= '0;
			end else if (cmd.append) begin
				count_q <= count_q + CNT_W'(1);
			end else if (cmd.pop) begin
				count_q <= count_q - CNT_W'(1);
			end
			if (cmd.set_open) begin
				open_q <= 1'b1;
			end else if (cmd.clr_open) begin
				open_q <= 1'b0;
			end
		end
	end

	// Numeric reference scan state.
	always_ff @(posedge clk) begin
		if (cmd.dec_start) begin
			k_q   <= '0;
			val_q <= '0;
			hex_q <= 1'b0;
			bad_q <= 1'b0;
		end else if (cmd.dec_step) begin
			k_q <= k_q + IDX_W'(1);
			if (k_q == '0) begin
				if (scan_ch != xeu_pkg::CH_HASH) begin
					bad_q <= 1'b1;
				end
			end else if (k_q == IDX_W'(1)
					&& (scan_ch == xeu_pkg::CH_LX || scan_ch == xeu_pkg::CH_UX)) begin
				hex_q <= 1'b1;
			end else if (!dig[4]) begin
				bad_q <= 1'b1;
			end else if (val_next > PRD_W'(xeu_pkg::NUM_LIMIT)) begin
				bad_q <= 1'b1;
			end else begin
				val_q <= val_next[xeu_pkg::NUM_W-1:0];
			end
		end
	end

	// Output register.
	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_byte_q <= emit_byte;
			out_last_q <= cmd.emit_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_byte  = out_byte_q;
	assign out_last  = out_last_q;
	assign out_valid = out_valid_q;

	assign st.c_amp      = c_q == xeu_pkg::CH_AMP;
	assign st.c_semi     = c_q == xeu_pkg::CH_SEMI;
	assign st.last       = last_q;
	assign st.open       = open_q;
	assign st.count_zero = count_q == '0;
	assign st.count_one  = count_q == CNT_W'(1);
	assign st.count_full = count_q == CNT_W'(CAP);
	assign st.head_amp   = held_q[0] == xeu_pkg::CH_AMP;
	assign st.k_end      = CNT_W'(k_q) + CNT_W'(1) == count_q;
	assign st.decode_ok  = named_hit || num_ok;
	assign st.slot_free  = !out_valid_q || out_ready;

endmodule

[hdl/xeu_ctrl.sv]
// Controller of the XML entity unescaper: state machine that sequences input,
// entity decoding, literal emission, overrun rescans and end-of-text flushes.
// Depends on xeu_pkg.
`timescale 1ns / 1ps

module xeu_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  xeu_pkg::dp_status_t st,
	output xeu_pkg::dp_cmd_t    cmd
);

	localparam logic [2:0] S_IDLE      = 3'd0;
	localparam logic [2:0] S_FEED      = 3'd1;
	localparam logic [2:0] S_RESCAN    = 3'd2;
	localparam logic [2:0] S_DEC       = 3'd3;
	localparam logic [2:0] S_DECIDE    = 3'd4;
	localparam logic [2:0] S_FLUSH_AMP = 3'd5;
	localparam logic [2:0] S_FLUSH_POP = 3'd6;
	localparam logic [2:0] S_SEMI      = 3'd7;

	logic [2:0] state_q, state_d;
	// Set when the literal run ends with a semicolon rather than closing the text.
	logic       semi_q, semi_d;

	assign in_ready = state_q == S_IDLE;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		semi_d  = semi_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load_in = 1'b1;
					state_d     = S_FEED;
				end
			end
			S_FEED: begin
				if (!st.open) begin
					if (st.c_amp) begin
						cmd.set_open  = 1'b1;
						cmd.clr_count = 1'b1;
						semi_d        = 1'b0;
						state_d       = st.last ? S_FLUSH_AMP : S_IDLE;
					end else if (st.slot_free) begin
						cmd.emit      = 1'b1;
						cmd.emit_sel  = xeu_pkg::EMIT_IN;
						cmd.emit_last = st.last;
						state_d       = S_IDLE;
					end
				end else if (st.c_semi) begin
					cmd.dec_start = 1'b1;
					state_d       = st.count_zero ? S_DECIDE : S_DEC;
				end else if (!st.count_full) begin
					cmd.append = 1'b1;
					semi_d     = 1'b0;
					state_d    = st.last ? S_FLUSH_AMP : S_IDLE;
				end else if (st.slot_free) begin
					cmd.append   = 1'b1;
					cmd.emit     = 1'b1;
					cmd.emit_sel = xeu_pkg::EMIT_AMP;
					cmd.clr_open = 1'b1;
					state_d      = S_RESCAN;
				end
			end
			S_RESCAN: begin
				if (st.head_amp) begin
					cmd.pop      = 1'b1;
					cmd.set_open = 1'b1;
					semi_d       = 1'b0;
					state_d      = st.last ? S_FLUSH_AMP : S_IDLE;
				end else if (st.slot_free) begin
					cmd.emit      = 1'b1;
					cmd.emit_sel  = xeu_pkg::EMIT_HEAD;
					cmd.emit_last = st.last && st.count_one;
					cmd.pop       = 1'b1;
					if (st.count_one) begin
						state_d = S_IDLE;
					end
				end
			end
			S_DEC: begin
				cmd.dec_step = 1'b1;
				if (st.k_end) begin
					state_d = S_DECIDE;
				end
			end
			S_DECIDE: begin
				if (!st.decode_ok) begin
					semi_d  = 1'b1;
					state_d = S_FLUSH_AMP;
				end else if (st.slot_free) begin
					cmd.emit      = 1'b1;
					cmd.emit_sel  = xeu_pkg::EMIT_DEC;
					cmd.emit_last = st.last;
					cmd.clr_open  = 1'b1;
					cmd.clr_count = 1'b1;
					state_d       = S_IDLE;
				end
			end
			S_FLUSH_AMP: begin
				if (st.slot_free) begin
					cmd.emit      = 1'b1;
					cmd.emit_sel  = xeu_pkg::EMIT_AMP;
					cmd.emit_last = !semi_q && st.last && st.count_zero;
					if (!st.count_zero) begin
						state_d = S_FLUSH_POP;
					end else if (semi_q) begin
						state_d = S_SEMI;
					end else begin
						cmd.clr_open = 1'b1;
						state_d      = S_IDLE;
					end
				end
			end
			S_FLUSH_POP: begin
				if (st.slot_free) begin
					cmd.emit      = 1'b1;
					cmd.emit_sel  = xeu_pkg::EMIT_HEAD;
					cmd.emit_last = !semi_q && st.last && st.count_one;
					cmd.pop       = 1'b1;
					if (st.count_one) begin
						if (semi_q) begin
							state_d = S_SEMI;
						end else begin
							cmd.clr_open = 1'b1;
							state_d      = S_IDLE;
						end
					end
				end
			end
			S_SEMI: begin
				if (st.slot_free) begin
					cmd.emit      = 1'b1;
					cmd.emit_sel  = xeu_pkg::EMIT_SEMI;
					cmd.emit_last = st.last;
					cmd.clr_open  = 1'b1;
					cmd.clr_count = 1'b1;
					state_d       = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			semi_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			semi_q  <= semi_d;
		end
	end

endmodule

[hdl/xml_entity_unescape.sv]
// Channel   | Direction | Handshake            | Payload
// ----------+-----------+----------------------+----------------------------
// input     | in        | in_valid / in_ready  | in_byte[7:0], in_last
// output    | out       | out_valid / out_ready| out_byte[7:0], out_last
//
// A plain byte, or one that only opens or extends an entity, is first accepted and then
// acted on by the controller in its own step. For a closing semicolon the scanner reads
// the held bytes, one held character a cycle, before a decision step in which a decoded
// entity leaves. Each literal byte after that (failed entity, end-of-text flush, overrun
// rescan) takes one more step, and a rescan that reopens an entity on an ampersand takes
// a step with no output.
// Reset clears the controller and the entity state at once; there is no clearing pass.
// While out_ready is low with a byte waiting, the controller holds each emitting step.
// Depends on xeu_pkg, xeu_ctrl and xeu_dp.
`timescale 1ns / 1ps

module xml_entity_unescape #(
	parameter int ENTITY_WINDOW = xeu_pkg::ENTITY_WINDOW_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic [7:0] in_byte,
	input  logic       in_last,
	input  logic       in_valid,
	output logic       in_ready,
	output logic [7:0] out_byte,
	output logic       out_last,
	output logic       out_valid,
	input  logic       out_ready
);

	// The controller only issues commands and reads flags; all bytes, the held
	// entity buffer, its fill count and the numeric value live in the datapath.
	xeu_pkg::dp_cmd_t    cmd;
	xeu_pkg::dp_status_t st;

	xeu_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.st       (st),
		.cmd      (cmd)
	);

	// The datapath holds up to ENTITY_WINDOW-1 bytes after an ampersand, and one
	// more briefly when a window overrun sends them back through the rescan.
	xeu_dp #(
		.ENTITY_WINDOW (ENTITY_WINDOW)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_byte   (in_byte),
		.in_last   (in_last),
		.out_byte  (out_byte),
		.out_last  (out_last),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd),
		.st        (st)
	);

	// A byte is only loaded into the output register when it is free or being taken.
	a_emit_slot: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> st.slot_free)
		else $error("output byte loaded while previous byte still waiting");

	// With no entity pending, the held buffer must have been drained.
	a_idle_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(in_ready && !st.open) |-> st.count_zero)
		else $error("held bytes left over with no entity pending");

	// The buffer is never written and shifted in the same cycle.
	a_no_push_pop: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.append && cmd.pop))
		else $error("held buffer appended and popped together");

	// Accepting a request always moves the controller into its processing step.
	a_accept_feed: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("controller ready again straight after accepting a request");

endmodule
